@@ design/srr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the selective-repeat receiver.
// Used by srr_ctrl, srr_datapath and selective_repeat_receiver; no dependencies.
package srr_pkg;

    localparam int SEQ_W   = 4;                // width of a sequence number
    localparam int SLOTS   = 1 << SEQ_W;       // slots in the receive buffer
    localparam int CNT_W   = SEQ_W + 1;        // holds counts up to SLOTS
    localparam int CFG_W   = 5;                // width of a configuration register

    localparam logic [CFG_W-1:0] SEQ_COUNT_RST   = CFG_W'(16);
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(8);
    localparam logic [CFG_W-1:0] SEQ_COUNT_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] SEQ_COUNT_MAX   = CFG_W'(SLOTS);
    localparam logic [CFG_W-1:0] WINDOW_MIN      = CFG_W'(1);

    // Configuration register indexes.
    localparam logic CFG_SEQ_COUNT   = 1'b0;
    localparam logic CFG_WINDOW_SIZE = 1'b1;

    // Result kinds.
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture the accepted input beat
        logic commit;      // store the payload if its slot is empty
        logic out_load;    // load the output register
        logic out_ack;     // output beat is an acknowledgement (else a delivery)
        logic walk_start;  // start the delivery walk at the window base
        logic walk_step;   // deliver the slot under the cursor
        logic base_norm;   // reduce the window base by the sequence count
    } srr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic base_ge_n;   // window base not yet reduced below the count
        logic drop;        // captured packet is dropped silently
        logic in_win;      // captured packet lies in the receive window
        logic at_base;     // captured packet is the window base
        logic walk_last;   // the slot under the cursor ends the delivered run
        logic out_free;    // output register can take a beat this cycle
    } srr_status_t;

endpackage

@@ design/selective_repeat_receiver.sv @@
`timescale 1ns / 1ps
// A packet is captured in the input registers; its acknowledgement beat is then registered in
// the output register once that is free. The controller evaluates one packet at a time; its
// walk reads one slot a cycle while the output register is free. Reset (aresetn low,
// synchronous) clears all slot marks at once, base to 0, seq_count to 16, window_size to 8.
// After a seq_count write at or below the base, the next packet waits until the base is reduced.
module selective_repeat_receiver #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write port: index 0 is seq_count, index 1 is window_size.
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [srr_pkg::CFG_W-1:0]  cfg_wr_data,
    // Arriving data packets.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [srr_pkg::SEQ_W-1:0]  s_seq_num,
    input  logic [PAYLOAD_BITS-1:0]    s_payload_word,
    input  logic                       s_checksum_ok,
    // Results: acknowledgements and in-order deliveries.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_out_kind,
    output logic [srr_pkg::SEQ_W-1:0]  m_ack_number,
    output logic [PAYLOAD_BITS-1:0]    m_delivered_word,
    output logic                       m_last_result
);
    import srr_pkg::*;

    // The controller walks through three phases. In idle it takes one input
    // beat, unless the window base still has to be reduced after a change of
    // the sequence count. In evaluate the datapath classifies the captured
    // packet against the receive window and the old window; a dropped packet
    // returns to idle without any result beat. Otherwise the acknowledgement
    // beat is loaded into the output register as soon as it is free, and a new
    // payload is stored in its slot. When the packet is the window base the
    // controller then walks the filled run, one delivered beat per cycle while
    // the output register is free, clearing each mark and finally moving the
    // base past the run.
    // The output register parts both sides, so a new packet can be accepted
    // while the last beat of the previous one still waits for the sink.

    srr_cmd_t    cmd;
    srr_status_t status;

    srr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srr_datapath #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_seq_num        (s_seq_num),
        .s_payload_word   (s_payload_word),
        .s_checksum_ok    (s_checksum_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_kind       (m_out_kind),
        .m_ack_number     (m_ack_number),
        .m_delivered_word (m_delivered_word),
        .m_last_result    (m_last_result),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

@@ design/srr_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the selective-repeat receiver: sequences evaluation and delivery.
// Depends on srr_pkg; drives srr_datapath through command and status structs.
module srr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srr_pkg::srr_status_t status,
    output srr_pkg::srr_cmd_t    cmd
);
    import srr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // The base is only reduced once a packet is offered, so that a
                // later change of the count still sees the unreduced base.
                s_ready       = !status.base_ge_n;
                cmd.base_norm = s_valid && status.base_ge_n;
                if (s_valid && !status.base_ge_n) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.drop) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_ack    = 1'b1;
                    cmd.commit     = status.in_win;
                    cmd.walk_start = status.in_win && status.at_base;
                    state_next     = (status.in_win && status.at_base) ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.walk_step = 1'b1;
                    if (status.walk_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/srr_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the selective-repeat receiver: configuration, window arithmetic,
// slot marks and payloads, delivery cursor and output register. Depends on srr_pkg.
module srr_datapath #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [srr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic [srr_pkg::SEQ_W-1:0]  s_seq_num,
    input  logic [PAYLOAD_BITS-1:0]    s_payload_word,
    input  logic                       s_checksum_ok,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_out_kind,
    output logic [srr_pkg::SEQ_W-1:0]  m_ack_number,
    output logic [PAYLOAD_BITS-1:0]    m_delivered_word,
    output logic                       m_last_result,
    input  srr_pkg::srr_cmd_t          cmd,
    output srr_pkg::srr_status_t       status
);
    import srr_pkg::*;

    logic [CFG_W-1:0]        seq_count_reg;
    logic [CFG_W-1:0]        window_size_reg;
    logic [SEQ_W-1:0]        base_reg;
    logic [SLOTS-1:0]        filled_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg [SLOTS];

    logic [SEQ_W-1:0]        seq_reg;
    logic [PAYLOAD_BITS-1:0] word_in_reg;
    logic                    good_reg;

    logic [SEQ_W-1:0]        cur_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [SEQ_W-1:0]        ack_reg;
    logic [PAYLOAD_BITS-1:0] word_out_reg;
    logic                    last_reg;

    logic [CFG_W-1:0]        win_w;
    logic [CFG_W-1:0]        old_lim;
    logic [CFG_W:0]          off_raw;
    logic [CFG_W-1:0]        off;
    logic [CFG_W-1:0]        cur_inc;
    logic [SEQ_W-1:0]        cur_next;
    logic [CFG_W-1:0]        cfg_seq_clamped;
    logic [CFG_W-1:0]        cfg_win_clamped;
    logic                    in_win;
    logic                    in_old;
    logic                    walk_last;

    // Window width in use and the start of the old window as an offset.
    assign win_w   = (window_size_reg > seq_count_reg) ? seq_count_reg : window_size_reg;
    assign old_lim = seq_count_reg - win_w;

    // Offset of the packet from the base; the base is below the count here.
    assign off_raw = {2'b00, seq_reg} + {1'b0, seq_count_reg} - {2'b00, base_reg};
    assign off     = (off_raw >= {1'b0, seq_count_reg})
                   ? CFG_W'(off_raw - {1'b0, seq_count_reg}) : off_raw[CFG_W-1:0];

    assign in_win = off < win_w;
    assign in_old = !in_win && (off >= old_lim);

    assign cur_inc   = {1'b0, cur_reg} + CFG_W'(1);
    assign cur_next  = (cur_inc == seq_count_reg) ? '0 : cur_inc[SEQ_W-1:0];
    assign walk_last = (cnt_reg + CNT_W'(1) == win_w) || !filled_reg[cur_next];

    assign status.base_ge_n = {1'b0, base_reg} >= seq_count_reg;
    assign status.drop      = !good_reg || ({1'b0, seq_reg} >= seq_count_reg)
                            || (!in_win && !in_old);
    assign status.in_win    = in_win;
    assign status.at_base   = seq_reg == base_reg;
    assign status.walk_last = walk_last;
    assign status.out_free  = !out_valid_reg || m_ready;

    assign cfg_seq_clamped = (cfg_wr_data < SEQ_COUNT_MIN) ? SEQ_COUNT_MIN
                           : (cfg_wr_data > SEQ_COUNT_MAX) ? SEQ_COUNT_MAX : cfg_wr_data;
    assign cfg_win_clamped = (cfg_wr_data < WINDOW_MIN) ? WINDOW_MIN
                           : (cfg_wr_data > seq_count_reg) ? seq_count_reg : cfg_wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_count_reg   <= SEQ_COUNT_RST;
            window_size_reg <= WINDOW_SIZE_RST;
            base_reg        <= '0;
            filled_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SEQ_COUNT) begin
                    seq_count_reg <= cfg_seq_clamped;
                end else begin
                    window_size_reg <= cfg_win_clamped;
                end
            end
            if (cmd.base_norm) begin
                base_reg <= SEQ_W'({1'b0, base_reg} - seq_count_reg);
            end else if (cmd.walk_step && walk_last) begin
                base_reg <= cur_next;
            end
            if (cmd.commit) begin
                filled_reg[seq_reg] <= 1'b1;
            end else if (cmd.walk_step) begin
                filled_reg[cur_reg] <= 1'b0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            seq_reg     <= s_seq_num;
            word_in_reg <= s_payload_word;
            good_reg    <= s_checksum_ok;
        end
        if (cmd.commit && !filled_reg[seq_reg]) begin
            payload_reg[seq_reg] <= word_in_reg;
        end
        if (cmd.walk_start) begin
            cur_reg <= seq_reg;
            cnt_reg <= '0;
        end else if (cmd.walk_step) begin
            cur_reg <= cur_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.out_load) begin
            if (cmd.out_ack) begin
                out_kind_reg <= KIND_ACK;
                ack_reg      <= seq_reg;
                word_out_reg <= '0;
                last_reg     <= !(in_win && (seq_reg == base_reg));
            end else begin
                out_kind_reg <= KIND_DELIVER;
                ack_reg      <= '0;
                word_out_reg <= payload_reg[cur_reg];
                last_reg     <= walk_last;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_kind       = out_kind_reg;
    assign m_ack_number     = ack_reg;
    assign m_delivered_word = word_out_reg;
    assign m_last_result    = last_reg;

    // A delivery only takes a slot that holds a payload.
    a_walk_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> filled_reg[cur_reg])
        else $error("delivery walk reached an empty slot");

    // The walk never runs past the window width.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> (cnt_reg < win_w))
        else $error("delivery walk ran past the window");

    // A beat is never loaded over one the sink has not taken.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output beat overwritten");

    // Packets are only evaluated against a reduced window base.
    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> ({1'b0, base_reg} < seq_count_reg))
        else $error("window base out of range during evaluation");

endmodule
